// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define SBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SBT_ASSERT_IMP(lbl, ante, cons, msg) \
  `SBT_ASSERT(lbl, (ante) |-> (cons), msg)
`endif

// ----- rtl/sbt_pkg.sv -----
// types and constants of the stereo blob triangulator
`default_nettype none
package sbt_pkg;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SMALL = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  localparam logic [1:0] REG_MIN_AREA   = 2'd0;
  localparam logic [1:0] REG_FOCAL_Q8   = 2'd1;
  localparam logic [1:0] REG_BASELINE   = 2'd2;
  localparam logic [1:0] REG_ROW_CENTER = 2'd3;

  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [15:0] min_area;
    logic [15:0] focal_q8;
    logic [15:0] baseline;
    logic [7:0]  row_center;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] xl;
    logic [8:0] xr;
    logic [7:0] yl;
    logic [7:0] yr;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_ABS, BK_MUL, BK_LOAD, BK_DIV, BK_STORE, BK_DONE
  } bk_state_e;

  typedef enum logic [1:0] {OP_Z, OP_X, OP_Y} op_e;
endpackage
`default_nettype wire

// ----- rtl/sbt_if.sv -----
// blob input and point output channel interfaces
`default_nettype none
interface sbt_blob_if;
  logic       valid;
  logic       ready;
  logic       camera;
  logic       present;
  logic [8:0] blob_x;
  logic [7:0] blob_y;
  logic [8:0] blob_width;
  logic [7:0] blob_height;
  logic       last;
  modport source (output valid, camera, present, blob_x, blob_y, blob_width,
                  blob_height, last, input ready);
  modport sink (input valid, camera, present, blob_x, blob_y, blob_width,
                blob_height, last, output ready);
endinterface

interface sbt_point_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, status, point_x, point_y, point_z, input ready);
  modport sink (input valid, status, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

// ----- rtl/sbt_front.sv -----
// front end: keeps the largest blob per camera and classifies each frame
`default_nettype none
module sbt_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire sbt_pkg::cfg_t cfg_i,
  sbt_blob_if.sink          blob_in,
  input  wire logic         q_full_i,
  output sbt_pkg::job_t     job_o,
  output logic              push_o
);
  import sbt_pkg::*;

  logic [16:0] la_q, la_d, ra_q, ra_d;
  logic [8:0]  lx_q, lx_d, rx_q, rx_d;
  logic [7:0]  ly_q, ly_d, ry_q, ry_d;
  logic [16:0] area;
  logic        acc, close;

  assign blob_in.ready = !q_full_i;
  assign acc   = blob_in.valid && blob_in.ready;
  assign close = acc && blob_in.camera && blob_in.last;
  assign area  = 17'(blob_in.blob_width) * 17'(blob_in.blob_height);

  always_comb begin
    la_d = la_q; lx_d = lx_q; ly_d = ly_q;
    ra_d = ra_q; rx_d = rx_q; ry_d = ry_q;
    if (acc && blob_in.present) begin
      if (!blob_in.camera) begin
        if (area > la_q) begin
          la_d = area; lx_d = blob_in.blob_x; ly_d = blob_in.blob_y;
        end
      end else if (area > ra_q) begin
        ra_d = area; rx_d = blob_in.blob_x; ry_d = blob_in.blob_y;
      end
    end
    job_o.xl = lx_d;
    job_o.xr = rx_d;
    job_o.yl = ly_d;
    job_o.yr = ry_d;
    if (la_d < {1'b0, cfg_i.min_area} || ra_d < {1'b0, cfg_i.min_area}) begin
      job_o.status = ST_SMALL;
    end else if (lx_d == rx_d) begin
      job_o.status = ST_ZERO;
    end else begin
      job_o.status = ST_OK;
    end
    push_o = close;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q <= '0; lx_q <= '0; ly_q <= '0;
      ra_q <= '0; rx_q <= '0; ry_q <= '0;
    end else if (close) begin
      la_q <= '0; lx_q <= '0; ly_q <= '0;
      ra_q <= '0; rx_q <= '0; ry_q <= '0;
    end else begin
      la_q <= la_d; lx_q <= lx_d; ly_q <= ly_d;
      ra_q <= ra_d; rx_q <= rx_d; ry_q <= ry_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sbt_fifo.sv -----
// short queue of closed frames between front and back
`default_nettype none
`include "assert_macros.svh"
module sbt_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sbt_pkg::job_t job_i,
  input  wire logic          pop_i,
  output sbt_pkg::job_t      job_o,
  output logic               full_o,
  output logic               empty_o
);
  import sbt_pkg::*;

  job_t       mem_q [QDEPTH];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'(QDEPTH);
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  `SBT_ASSERT(a_cnt_bound, cnt_q <= 2'(QDEPTH), "queue count beyond depth")
  `SBT_ASSERT_IMP(a_pop_nonempty, pop_i, cnt_q != 2'd0, "pop from empty queue")
endmodule
`default_nettype wire

// ----- rtl/sbt_back.sv -----
// back end: triangulates one frame with a shared bit-serial divider
`default_nettype none
`include "assert_macros.svh"
module sbt_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sbt_pkg::cfg_t cfg_i,
  input  wire sbt_pkg::job_t job_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  sbt_point_if.source        point_out
);
  import sbt_pkg::*;

  localparam int unsigned NW = 33 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  bk_state_e state_q, state_d;
  op_e       op_q;
  logic [CW-1:0] cnt_q;
  job_t      job_q;
  logic [8:0]  ad_q;
  logic        nd_q, nkx_q, nky_q;
  logic [10:0] mx_q;
  logic [8:0]  my_q;
  logic [31:0] fb_q;
  logic [26:0] bmx_q;
  logic [24:0] bmy_q;
  logic [NW-1:0] num_q;
  logic [16:0] den_q, rem_q;
  logic        neg_q;
  logic [31:0] px_q, py_q, pz_q;
  logic        out_vld_q;
  logic [1:0]  out_st_q;
  logic [31:0] out_x_q, out_y_q, out_z_q;
  logic        ld_out;

  logic signed [9:0]  d;
  logic signed [11:0] kx;
  logic signed [10:0] ky;
  logic [10:0] kx_abs;
  logic [8:0]  ky_abs;
  logic [8:0]  d_abs;
  logic [NW-1:0] mag;
  logic [16:0] den;
  logic        neg;
  logic [17:0] r2;
  logic        ge;
  logic [31:0] sat;

  always_comb begin
    d  = $signed({1'b0, job_q.xl}) - $signed({1'b0, job_q.xr});
    kx = $signed(12'({job_q.xl, 1'b0}) + 12'(job_q.xl)) - $signed(12'(job_q.xr));
    ky = $signed(11'(job_q.yl) + 11'(job_q.yr)) - $signed(11'({cfg_i.row_center, 1'b0}));
    d_abs  = d[9] ? 9'(-d) : 9'(d);
    kx_abs = kx[11] ? 11'(-kx) : 11'(kx);
    ky_abs = ky[10] ? 9'(-ky) : 9'(ky);
  end

  always_comb begin
    case (op_q)
      OP_Z: begin
        mag = NW'(fb_q) << FRAC_BITS;
        den = {ad_q, 8'd0};
        neg = !nd_q;
      end
      OP_X: begin
        mag = NW'(bmx_q) << FRAC_BITS;
        den = 17'({ad_q, 1'b0});
        neg = nkx_q == nd_q;
      end
      default: begin
        mag = NW'(bmy_q) << FRAC_BITS;
        den = 17'({ad_q, 1'b0});
        neg = nky_q != nd_q;
      end
    endcase
    r2 = {rem_q, num_q[NW-1]};
    ge = r2 >= {1'b0, den_q};
    if (neg_q) begin
      sat = (num_q > NW'(33'h080000000)) ? 32'h80000000 : 32'(-num_q[31:0]);
    end else begin
      sat = (num_q > NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : num_q[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!empty_i) state_d = BK_ABS;
      BK_ABS:   state_d = (job_q.status == ST_OK) ? BK_MUL : BK_DONE;
      BK_MUL:   state_d = BK_LOAD;
      BK_LOAD:  state_d = BK_DIV;
      BK_DIV:   if (cnt_q == CW'(1)) state_d = BK_STORE;
      BK_STORE: state_d = (op_q == OP_Y) ? BK_DONE : BK_LOAD;
      BK_DONE:  if (!out_vld_q || point_out.ready) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = (state_q == BK_IDLE) && !empty_i;
    ld_out = (state_q == BK_DONE) && (!out_vld_q || point_out.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      op_q      <= OP_Z;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_MUL) op_q <= OP_Z;
      else if (state_q == BK_STORE) begin
        case (op_q)
          OP_Z:    op_q <= OP_X;
          OP_X:    op_q <= OP_Y;
          default: op_q <= OP_Z;
        endcase
      end
      if (state_q == BK_LOAD) cnt_q <= CW'(NW);
      else if (state_q == BK_DIV) cnt_q <= cnt_q - CW'(1);
      if (ld_out) out_vld_q <= 1'b1;
      else if (point_out.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (state_q == BK_ABS) begin
      ad_q  <= d_abs;
      nd_q  <= d[9];
      mx_q  <= kx_abs;
      nkx_q <= kx[11];
      my_q  <= ky_abs;
      nky_q <= ky[10];
      px_q  <= '0;
      py_q  <= '0;
      pz_q  <= '0;
    end
    if (state_q == BK_MUL) begin
      fb_q  <= 32'(cfg_i.focal_q8) * 32'(cfg_i.baseline);
      bmx_q <= 27'(cfg_i.baseline) * 27'(mx_q);
      bmy_q <= 25'(cfg_i.baseline) * 25'(my_q);
    end
    if (state_q == BK_LOAD) begin
      num_q <= mag + NW'(den >> 1);
      den_q <= den;
      rem_q <= '0;
      neg_q <= neg;
    end
    if (state_q == BK_DIV) begin
      rem_q <= ge ? 17'(r2 - {1'b0, den_q}) : r2[16:0];
      num_q <= {num_q[NW-2:0], ge};
    end
    if (state_q == BK_STORE) begin
      case (op_q)
        OP_Z:    pz_q <= sat;
        OP_X:    px_q <= sat;
        default: py_q <= sat;
      endcase
    end
    if (ld_out) begin
      out_st_q <= job_q.status;
      out_x_q  <= px_q;
      out_y_q  <= py_q;
      out_z_q  <= pz_q;
    end
  end

  assign point_out.valid   = out_vld_q;
  assign point_out.status  = out_st_q;
  assign point_out.point_x = out_x_q;
  assign point_out.point_y = out_y_q;
  assign point_out.point_z = out_z_q;

  `SBT_ASSERT_IMP(a_div_cnt, state_q == BK_DIV, cnt_q != '0, "divider count ran out")
  `SBT_ASSERT_IMP(a_bad_zero, out_vld_q && out_st_q != ST_OK, out_x_q == '0 && out_y_q == '0 && out_z_q == '0, "invalid point carries coordinates")
endmodule
`default_nettype wire

// ----- rtl/stereo_blob_triangulator_top.sv -----
// top level of the stereo blob triangulator
`default_nettype none
// Blob words are taken one per cycle; blob_in stalls only while two closed frames
// wait in the queue. A frame closes on a camera 1 word with last set and yields one
// point word. The back end works through each closed frame in turn with the
// one-bit-per-cycle divider that the three coordinates share; frames that fail
// the area or disparity check skip the divider.
module stereo_blob_triangulator_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  sbt_blob_if.sink         blob_in,
  sbt_point_if.source      point_out
);
  import sbt_pkg::*;

  cfg_t cfg_q;
  job_t push_job, pop_job;
  logic push, pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_area   <= 16'd10;
      cfg_q.focal_q8   <= 16'd717;
      cfg_q.baseline   <= 16'd610;
      cfg_q.row_center <= 8'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_AREA:   cfg_q.min_area   <= cfg_data_i;
        REG_FOCAL_Q8:   cfg_q.focal_q8   <= cfg_data_i;
        REG_BASELINE:   cfg_q.baseline   <= cfg_data_i;
        REG_ROW_CENTER: cfg_q.row_center <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sbt_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .blob_in,
    .q_full_i(q_full), .job_o(push_job), .push_o(push)
  );

  sbt_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .job_i(push_job), .pop_i(pop),
    .job_o(pop_job), .full_o(q_full), .empty_o(q_empty)
  );

  sbt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .job_i(pop_job), .empty_i(q_empty),
    .pop_o(pop), .point_out
  );
endmodule
`default_nettype wire
